// ----- rtl/core/nkp_pkg.sv -----
package nkp_pkg;

  localparam int MAX_VALUES = 16;
  localparam int SLOTS      = 16;
  localparam int N_CAP      = (MAX_VALUES < SLOTS) ? MAX_VALUES : SLOTS;
  localparam int POS_W      = $clog2(SLOTS);
  localparam int VAL_W      = 4;
  localparam int CNT_W      = 5;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic REG_CHOOSE_COUNT = 1'b0;
  localparam logic REG_VALUE_COUNT  = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [POS_W-1:0] in_position;
    logic [VAL_W-1:0] in_value;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0] out_position;
    logic [VAL_W-1:0] out_value;
    logic             last;
    logic             exhausted;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREFIX,
    ST_SCAN,
    ST_FILL,
    ST_EMIT,
    ST_EXH
  } state_e;

  typedef struct packed {
    logic start;
    logic load;
    logic prefix;
    logic scan;
    logic fill;
    logic emit;
    logic exh;
  } ctl_t;

  typedef struct packed {
    logic cnt_last;
    logic cnt_zero;
    logic hit;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] index;
  } pick_t;

  function automatic pick_t first_set(input logic [SLOTS-1:0] mask);
    pick_t r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        r.found = 1'b1;
        r.index = VAL_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/nkp_ctrl.sv -----
module nkp_ctrl
  import nkp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_cmd_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_cmd_i == CMD_ADVANCE) begin
            ctl_o.start = 1'b1;
            state_d     = ST_PREFIX;
          end else begin
            ctl_o.load = 1'b1;
          end
        end
      end
      ST_PREFIX: begin
        ctl_o.prefix = 1'b1;
        if (sts_i.cnt_last) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        ctl_o.scan = 1'b1;
        if (sts_i.hit) begin
          state_d = sts_i.cnt_last ? ST_EMIT : ST_FILL;
        end else if (sts_i.cnt_zero) begin
          state_d = ST_EXH;
        end
      end
      ST_FILL: begin
        ctl_o.fill = 1'b1;
        if (sts_i.cnt_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        ctl_o.emit = 1'b1;
        if (sts_i.out_free && sts_i.cnt_last) state_d = ST_IDLE;
      end
      ST_EXH: begin
        ctl_o.exh = 1'b1;
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/nkp_dp.sv -----
module nkp_dp
  import nkp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  in_word_t         in_word_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_index_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  input  ctl_t             ctl_i,
  output sts_t             sts_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_word_o
);

  logic [CNT_W-1:0] choose_q, value_q;
  logic [CNT_W-1:0] n_eff, k_eff;
  logic [POS_W-1:0] km1;
  logic [VAL_W-1:0] arr_q [SLOTS];
  logic [SLOTS-1:0] prefix_q [SLOTS];
  logic [SLOTS-1:0] acc_q, used_q;
  logic [POS_W-1:0] cnt_q;
  logic             out_valid_q;
  out_word_t        out_word_q;
  logic [VAL_W-1:0] cur_val;
  logic [SLOTS-1:0] n_mask, above_mask;
  pick_t            scan_pick, fill_pick;
  logic             out_free;

  always_comb begin
    n_eff = value_q;
    if (n_eff == '0) n_eff = CNT_W'(1);
    if (n_eff > CNT_W'(N_CAP)) n_eff = CNT_W'(N_CAP);
    k_eff = choose_q;
    if (k_eff == '0) k_eff = CNT_W'(1);
    if (k_eff > CNT_W'(SLOTS)) k_eff = CNT_W'(SLOTS);
    if (k_eff > n_eff) k_eff = n_eff;
  end

  assign km1     = POS_W'(k_eff - CNT_W'(1));
  assign cur_val = arr_q[cnt_q];

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      n_mask[i]     = (CNT_W'(i) < n_eff);
      above_mask[i] = (VAL_W'(i) > cur_val);
    end
  end

  assign scan_pick = first_set(~prefix_q[cnt_q] & n_mask & above_mask);
  assign fill_pick = first_set(~used_q & n_mask);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign sts_o.cnt_last = (cnt_q == km1);
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.hit      = scan_pick.found;
  assign sts_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      choose_q <= CNT_W'(16);
      value_q  <= CNT_W'(16);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CHOOSE_COUNT: choose_q <= cfg_data_i;
        REG_VALUE_COUNT:  value_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) arr_q[i] <= VAL_W'(i);
    end else if (ctl_i.load) begin
      arr_q[in_word_i.in_position] <= in_word_i.in_value;
    end else if (ctl_i.scan && scan_pick.found) begin
      arr_q[cnt_q] <= scan_pick.index;
    end else if (ctl_i.fill) begin
      arr_q[cnt_q] <= fill_pick.index;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.prefix) prefix_q[cnt_q] <= acc_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      acc_q <= '0;
    end else if (ctl_i.prefix) begin
      acc_q <= acc_q | (SLOTS'(1) << cur_val);
    end
    if (ctl_i.scan) begin
      used_q <= prefix_q[cnt_q] | (SLOTS'(1) << scan_pick.index);
    end else if (ctl_i.fill) begin
      used_q <= used_q | (SLOTS'(1) << fill_pick.index);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.start) begin
      cnt_q <= '0;
    end else if (ctl_i.prefix) begin
      if (cnt_q != km1) cnt_q <= cnt_q + POS_W'(1);
    end else if (ctl_i.scan) begin
      if (scan_pick.found) begin
        cnt_q <= (cnt_q == km1) ? '0 : cnt_q + POS_W'(1);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - POS_W'(1);
      end
    end else if (ctl_i.fill) begin
      cnt_q <= (cnt_q == km1) ? '0 : cnt_q + POS_W'(1);
    end else if (ctl_i.emit && out_free) begin
      cnt_q <= (cnt_q == km1) ? '0 : cnt_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((ctl_i.emit || ctl_i.exh) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit && out_free) begin
      out_word_q.out_position <= cnt_q;
      out_word_q.out_value    <= cur_val;
      out_word_q.last         <= (cnt_q == km1);
      out_word_q.exhausted    <= 1'b0;
    end else if (ctl_i.exh && out_free) begin
      out_word_q.out_position <= '0;
      out_word_q.out_value    <= '0;
      out_word_q.last         <= 1'b1;
      out_word_q.exhausted    <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- rtl/core/next_k_permutation_generator.sv -----
// Channel  Direction  Handshake           Word
// in       input      in_valid_i/stall_o  in_word_t: cmd, in_position, in_value
// out      output     out_valid_o/stall_i out_word_t: out_position, out_value, last, exhausted
// cfg      input      cfg_valid_i/ready_o cfg_index_i, cfg_data_i
//
// A load writes one arrangement position while idle. An advance is accepted, then builds the
// prefix used-sets for the k positions, scans backward for the rightmost position that can
// take a larger unused value, refills the positions after it, then emits one word per
// position; when no successor exists it emits a single exhausted word instead.
// Reset restores the identity arrangement and k = n = 16.
// A stalled output holds the word and pauses emission; in_stall_o is high while busy.
module next_k_permutation_generator
  import nkp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_word_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [CNT_W-1:0] cfg_data_i
);

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  nkp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_word_i.cmd),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  nkp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import nkp_pkg::*;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_word_t         in_word_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_word_t        out_word_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic             cfg_index_i = REG_CHOOSE_COUNT;
  logic [CNT_W-1:0] cfg_data_i  = '0;

  next_k_permutation_generator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [VAL_W-1:0] arrangement_model [SLOTS];
  logic [CNT_W-1:0] choose_reg;
  logic [CNT_W-1:0] value_reg;
  out_word_t        pending_words [$];
  int               errors     = 0;
  int               burst_left = 0;
  int               stall_mode = 0;
  int               mode_left  = 0;
  int               stall_tick = 0;

  function automatic int effective_values();
    int n;
    n = value_reg;
    if (n == 0) n = 1;
    if (n > N_CAP) n = N_CAP;
    return n;
  endfunction

  function automatic int effective_choose();
    int k;
    k = choose_reg;
    if (k == 0) k = 1;
    if (k > SLOTS) k = SLOTS;
    if (k > effective_values()) k = effective_values();
    return k;
  endfunction

  function automatic in_word_t make_word(logic cmd, int pos, int val);
    in_word_t w;
    w.cmd         = cmd;
    w.in_position = POS_W'(pos);
    w.in_value    = VAL_W'(val);
    return w;
  endfunction

  // Apply a load, or step the arrangement to its successor and queue the words it produces.
  function automatic void step_arrangement(in_word_t w);
    int          n;
    int          k;
    int          free_val;
    bit          found;
    logic [15:0] used;
    out_word_t   o;
    if (w.cmd == CMD_LOAD) begin
      arrangement_model[w.in_position] = w.in_value;
      return;
    end
    n = effective_values();
    k = effective_choose();
    found = 1'b0;
    for (int i = k - 1; i >= 0 && !found; i--) begin
      used = '0;
      for (int p = 0; p < i; p++) used[arrangement_model[p]] = 1'b1;
      for (int v = int'(arrangement_model[i]) + 1; v < n && !found; v++) begin
        if (!used[v]) begin
          found = 1'b1;
          arrangement_model[i] = VAL_W'(v);
          used[v] = 1'b1;
          for (int q = i + 1; q < k; q++) begin
            for (free_val = 0; free_val < n; free_val++)
              if (!used[free_val]) break;
            if (free_val >= n) free_val = 0;
            arrangement_model[q] = VAL_W'(free_val);
            used[free_val] = 1'b1;
          end
        end
      end
    end
    if (!found) begin
      o = '0;
      o.last = 1'b1;
      o.exhausted = 1'b1;
      pending_words.push_back(o);
    end else begin
      for (int p = 0; p < k; p++) begin
        o.out_position = POS_W'(p);
        o.out_value    = arrangement_model[p];
        o.last         = (p == k - 1);
        o.exhausted    = 1'b0;
        pending_words.push_back(o);
      end
    end
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    step_arrangement(w);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic load_pos(int pos, int val);
    send_word(make_word(CMD_LOAD, pos, val));
  endtask

  task automatic advance();
    send_word(make_word(CMD_ADVANCE, 0, $urandom_range(0, 15)));
  endtask

  // Hold off input until every expected word is out and the block has gone quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_counts(int k, int n);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_CHOOSE_COUNT;
    cfg_data_i  <= CNT_W'(k);
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    choose_reg = CNT_W'(k);
    @(negedge clk_i);
    cfg_index_i <= REG_VALUE_COUNT;
    cfg_data_i  <= CNT_W'(n);
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    value_reg = CNT_W'(n);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_advance();
    advance();
  endtask

  task automatic test_load_extremes();
    load_pos(15, 0);
    load_pos(0, 15);
    advance();
    load_pos(0, 0);
    advance();
  endtask

  task automatic test_count_extremes();
    set_counts(0, 0);
    load_pos(0, 0);
    advance();
    set_counts(31, 31);
    advance();
    set_counts(31, 4);
    load_pos(0, 9);
    load_pos(1, 3);
    advance();
  endtask

  task automatic test_exhaustion_walk();
    set_counts(2, 3);
    load_pos(0, 0);
    load_pos(1, 1);
    repeat (7) advance();
  endtask

  task automatic test_random_arrangements();
    int sent;
    int pick;
    int shape;
    int k;
    int n;
    int j;
    int tmp;
    int perm [16];
    sent = 0;
    while (sent < 355) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        n = $urandom_range(1, 5);
        set_counts($urandom_range(1, n), n);
      end else if (pick < 17) begin
        set_counts($urandom_range(1, 16), $urandom_range(1, 16));
      end else begin
        set_counts($urandom_range(0, 31), $urandom_range(0, 31));
      end
      n = effective_values();
      k = effective_choose();
      shape = $urandom_range(0, 9);
      if (shape < 7) begin
        for (int i = 0; i < 16; i++) perm[i] = i;
        for (int i = n - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (int p = 0; p < k; p++) load_pos(p, perm[p]);
        sent += k;
      end else begin
        tmp = (shape < 9) ? k : $urandom_range(1, 4);
        repeat (tmp) load_pos($urandom_range(0, 15), $urandom_range(0, 15));
        sent += tmp;
      end
      tmp = $urandom_range(1, 10);
      repeat (tmp) begin
        if ($urandom_range(0, 9) == 0) begin
          load_pos($urandom_range(0, 15), $urandom_range(0, 15));
          sent++;
        end
        advance();
        sent++;
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(40, 300);
    end else begin
      mode_left--;
    end
    stall_tick++;
    case (stall_mode)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= ($urandom_range(0, 9) < 3);
      end
      2: begin
        out_stall_i <= ((stall_tick % 5) < 2);
      end
      default: begin
        out_stall_i <= ((stall_tick % 8) != 0);
      end
    endcase
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word pos %0d value %0d last %0b exhausted %0b", $time,
                 out_word_o.out_position, out_word_o.out_value, out_word_o.last,
                 out_word_o.exhausted);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (out_word_o !== want) begin
          $display("%0t: expected %0d/%0d/%0b/%0b, actual %0d/%0d/%0b/%0b",
                   $time, want.out_position, want.out_value, want.last, want.exhausted,
                   out_word_o.out_position, out_word_o.out_value, out_word_o.last,
                   out_word_o.exhausted);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("next_k_permutation_generator verification failed");
    $finish;
  end

  initial begin
    for (int p = 0; p < SLOTS; p++) arrangement_model[p] = VAL_W'(p);
    choose_reg = CNT_W'(16);
    value_reg  = CNT_W'(16);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_advance();
    test_load_extremes();
    test_count_extremes();
    test_exhaustion_walk();
    test_random_arrangements();
    settle();
    if (errors == 0) begin
      $display("next_k_permutation_generator verification clean");
    end else begin
      $display("next_k_permutation_generator verification failed");
    end
    $finish;
  end

endmodule
